// ===== rtl/core/lrai_pkg.sv =====
package lrai_pkg;

  localparam int unsigned LASERS     = 16;
  localparam int unsigned HALVES     = 2;
  localparam int unsigned BLOCK_SIZE = LASERS * HALVES;

  localparam int unsigned PTR_W   = (BLOCK_SIZE > 1) ? $clog2(BLOCK_SIZE) : 1;
  localparam int unsigned CNT_W   = $clog2(BLOCK_SIZE + 1);
  localparam int unsigned LASER_W = (LASERS > 1) ? $clog2(LASERS) : 1;

  localparam int unsigned FULL_CIRCLE = 36000;
  localparam int unsigned TWO_CIRCLE  = 2 * FULL_CIRCLE;
  localparam int unsigned AZ_MAX      = 131071;
  localparam int unsigned DELAY_MAX   = 1048575;
  localparam int unsigned ROUND_HALF  = 65536;

  localparam int unsigned ENTRY_W = 24;
  localparam int unsigned STEP_W  = 33;
  localparam int unsigned ACC_W   = 40;
  localparam int unsigned DLY_W   = 22;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] CFG_STEP_RATIO     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_INTERVAL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LO       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HI       = 3'd4;

  typedef struct packed {
    logic apply_port;
    logic apply_pend;
    logic capture;
    logic init;
    logic load;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic port_end_emit;
    logic pend_end_emit;
    logic out_free;
    logic last_point;
  } dp_status_t;

endpackage

// ===== rtl/core/lrai_ctrl.sv =====
module lrai_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lrai_pkg::dp_status_t st,
  output lrai_pkg::dp_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_APPLY = 7'b0000010,
    S_SUM   = 7'b0000100,
    S_WRAP  = 7'b0001000,
    S_SPAN  = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_EMIT  = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    pend_next  = pend;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (st.full) begin
            cmd.capture = 1'b1;
            pend_next   = 1'b1;
            state_next  = S_SUM;
          end else begin
            cmd.apply_port = 1'b1;
            if (st.port_end_emit) begin
              state_next = S_SUM;
            end
          end
        end
      end
      S_APPLY: begin
        cmd.apply_pend = 1'b1;
        pend_next      = 1'b0;
        state_next     = st.pend_end_emit ? S_SUM : S_IDLE;
      end
      S_SUM:  state_next = S_WRAP;
      S_WRAP: state_next = S_SPAN;
      S_SPAN: state_next = S_STEP;
      S_STEP: begin
        cmd.init   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.load = 1'b1;
          if (st.last_point) begin
            state_next = pend ? S_APPLY : S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

endmodule

// ===== rtl/core/lrai_dpath.sv =====
module lrai_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  input  logic [lrai_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lrai_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [15:0]                         block_azimuth,
  input  logic [15:0]                         raw_range,
  input  logic [7:0]                          raw_reflectivity,
  input  logic                                packet_end,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic [3:0]                          laser_index,
  output logic                                half_index,
  output logic [16:0]                         point_azimuth,
  output logic [15:0]                         point_range,
  output logic [7:0]                          point_reflectivity,
  output logic [19:0]                         delay_ns,
  output logic                                range_valid,
  output logic                                block_done,
  input  lrai_pkg::dp_cmd_t                   cmd,
  output lrai_pkg::dp_status_t                st
);

  localparam int unsigned CNT_W   = lrai_pkg::CNT_W;
  localparam int unsigned PTR_W   = lrai_pkg::PTR_W;
  localparam int unsigned LASER_W = lrai_pkg::LASER_W;
  localparam int unsigned ACC_W   = lrai_pkg::ACC_W;
  localparam int unsigned DLY_W   = lrai_pkg::DLY_W;
  localparam int unsigned AZF_W   = ACC_W - 17;

  // configuration
  logic [15:0] step_ratio, laser_interval, range_lo, range_hi;
  logic [17:0] block_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_ratio     <= 16'd3539;
      laser_interval <= 16'd3000;
      block_interval <= 18'd55500;
      range_lo       <= 16'd2;
      range_hi       <= 16'd20000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lrai_pkg::CFG_STEP_RATIO:     step_ratio     <= cfg_data[15:0];
        lrai_pkg::CFG_LASER_INTERVAL: laser_interval <= cfg_data[15:0];
        lrai_pkg::CFG_BLOCK_INTERVAL: block_interval <= cfg_data;
        lrai_pkg::CFG_RANGE_LO:       range_lo       <= cfg_data[15:0];
        lrai_pkg::CFG_RANGE_HI:       range_hi       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // packet state
  logic [CNT_W-1:0] count;
  logic [15:0]      held, prior;
  logic [1:0]       seen;

  logic [15:0] pend_az, pend_range;
  logic [7:0]  pend_refl;
  logic        pend_end;

  logic        apply;
  logic [15:0] src_az, src_range;
  logic [7:0]  src_refl;
  logic        src_end, src_end_emit;
  logic        count_zero;
  logic [15:0] held_new, prior_new;
  logic [1:0]  seen_new;
  logic        port_end_emit, pend_end_emit;

  assign apply      = cmd.apply_port | cmd.apply_pend;
  assign src_az     = cmd.apply_pend ? pend_az    : block_azimuth;
  assign src_range  = cmd.apply_pend ? pend_range : raw_range;
  assign src_refl   = cmd.apply_pend ? pend_refl  : raw_reflectivity;
  assign src_end    = cmd.apply_pend ? pend_end   : packet_end;
  assign count_zero = (count == '0);
  assign held_new   = count_zero ? src_az : held;
  assign prior_new  = count_zero ? held : prior;
  assign seen_new   = (count_zero && seen != 2'd2) ? seen + 2'd1 : seen;

  assign port_end_emit = packet_end && (count == CNT_W'(lrai_pkg::BLOCK_SIZE - 1));
  assign pend_end_emit = pend_end && (count == CNT_W'(lrai_pkg::BLOCK_SIZE - 1));
  assign src_end_emit  = cmd.apply_pend ? pend_end_emit : port_end_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      held  <= '0;
      prior <= '0;
      seen  <= '0;
    end else if (cmd.capture) begin
      count <= '0;
    end else if (apply) begin
      held  <= held_new;
      prior <= prior_new;
      if (src_end) begin
        count <= '0;
        seen  <= '0;
      end else begin
        count <= count + 1'b1;
        seen  <= seen_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pend_az    <= block_azimuth;
      pend_range <= raw_range;
      pend_refl  <= raw_reflectivity;
      pend_end   <= packet_end;
    end
  end

  // emission base: held azimuth t and its difference d
  logic [16:0] em_t, em_d;
  logic [16:0] next_d, last_t, last_d;
  logic        last_lt;

  assign next_d  = (block_azimuth < held)
                 ? 17'(block_azimuth) + 17'(lrai_pkg::FULL_CIRCLE) - 17'(held)
                 : 17'(block_azimuth) - 17'(held);
  assign last_lt = held_new < prior_new;
  assign last_t  = (seen_new >= 2'd2 && last_lt)
                 ? 17'(held_new) + 17'(lrai_pkg::FULL_CIRCLE) : 17'(held_new);
  assign last_d  = (seen_new >= 2'd2) ? last_t - 17'(prior_new) : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      em_t <= 17'(held);
      em_d <= next_d;
    end else if (apply && src_end_emit) begin
      em_t <= last_t;
      em_d <= last_d;
    end
  end

  // span and step, computed in a chain of registered stages
  logic [17:0]                 t2_r;
  logic [18:0]                 r0_r, r2_r;
  logic [16:0]                 span_r;
  logic [lrai_pkg::STEP_W-1:0] step_r;

  always_ff @(posedge clk) begin
    t2_r   <= {em_t, 1'b0};
    r0_r   <= 19'({em_t, 1'b0}) + 19'(em_d);
    r2_r   <= (r0_r > 19'(lrai_pkg::TWO_CIRCLE)) ? r0_r - 19'(lrai_pkg::TWO_CIRCLE) : r0_r;
    span_r <= (19'(t2_r) > r2_r)
            ? 17'(r2_r + 19'(lrai_pkg::TWO_CIRCLE) - 19'(t2_r))
            : 17'(r2_r - 19'(t2_r));
    step_r <= lrai_pkg::STEP_W'(span_r) * lrai_pkg::STEP_W'(step_ratio);
  end

  // return store
  logic [lrai_pkg::ENTRY_W-1:0] ret_mem [lrai_pkg::BLOCK_SIZE];
  logic [lrai_pkg::ENTRY_W-1:0] rd_data;
  logic [PTR_W-1:0]             p, p_inc, rd_addr;

  assign p_inc   = p + 1'b1;
  assign rd_addr = cmd.init ? '0 : (cmd.load ? p_inc : p);

  always_ff @(posedge clk) begin
    if (apply) begin
      ret_mem[count[PTR_W-1:0]] <= {src_refl, src_range};
    end
    rd_data <= ret_mem[rd_addr];
  end

  // point generation
  logic [LASER_W-1:0] laser;
  logic               half;
  logic [ACC_W-1:0]   acc, az_sum;
  logic [DLY_W-1:0]   dly, dly_sum;
  logic [AZF_W-1:0]   az_full;
  logic [16:0]        az_sat;
  logic [19:0]        dly_sat;
  logic [15:0]        rd_range;

  assign az_sum  = acc + ACC_W'(lrai_pkg::ROUND_HALF);
  assign az_full = az_sum[ACC_W-1:17];
  assign az_sat  = (az_full > AZF_W'(lrai_pkg::AZ_MAX)) ? 17'(lrai_pkg::AZ_MAX) : az_full[16:0];
  assign dly_sum = dly + (half ? DLY_W'(block_interval[17:1]) : '0);
  assign dly_sat = (dly_sum > DLY_W'(lrai_pkg::DELAY_MAX))
                 ? 20'(lrai_pkg::DELAY_MAX) : dly_sum[19:0];
  assign rd_range = rd_data[15:0];

  assign st.full          = (count == CNT_W'(lrai_pkg::BLOCK_SIZE));
  assign st.port_end_emit = port_end_emit;
  assign st.pend_end_emit = pend_end_emit;
  assign st.out_free      = !out_valid || !out_stall;
  assign st.last_point    = (p == PTR_W'(lrai_pkg::BLOCK_SIZE - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      p     <= '0;
      laser <= '0;
      half  <= 1'b0;
    end else if (cmd.init) begin
      p     <= '0;
      laser <= '0;
      half  <= 1'b0;
    end else if (cmd.load) begin
      p <= p_inc;
      if (laser == LASER_W'(lrai_pkg::LASERS - 1)) begin
        laser <= '0;
        half  <= 1'b1;
      end else begin
        laser <= laser + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      acc <= ACC_W'({t2_r, 16'b0});
      dly <= '0;
    end else if (cmd.load) begin
      if (laser == LASER_W'(lrai_pkg::LASERS - 1)) begin
        acc <= ACC_W'({r2_r, 16'b0});
        dly <= '0;
      end else begin
        acc <= acc + ACC_W'(step_r);
        dly <= dly + DLY_W'(laser_interval);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      laser_index        <= 4'(laser);
      half_index         <= half;
      point_azimuth      <= az_sat;
      point_range        <= rd_range;
      point_reflectivity <= rd_data[23:16];
      delay_ns           <= dly_sat;
      range_valid        <= (rd_range > range_lo) && (rd_range < range_hi);
      block_done         <= st.last_point;
    end
  end

endmodule

// ===== rtl/core/lidar_return_azimuth_interpolator_top.sv =====
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   block_azimuth, raw_range, raw_reflectivity,
//                                            packet_end
// out       source     out_valid / out_stall laser_index .. block_done
// cfg       sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// A return is taken only while the controller is idle, not during block setup or emission.
// A complete block goes out after span/step setup in the SUM, WRAP, SPAN and STEP
// states, then one point per cycle, 32 points in all, from the return store; out_stall
// pauses the walk. A return arriving on a full store waits in a holding register and
// is written in the cycle after the last point of the block is loaded, so the input
// stalls through the setup and emission of that block. rst is synchronous and restores the defaults.
module lidar_return_azimuth_interpolator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] block_azimuth,
  input  logic [15:0] raw_range,
  input  logic [7:0]  raw_reflectivity,
  input  logic        packet_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  laser_index,
  output logic        half_index,
  output logic [16:0] point_azimuth,
  output logic [15:0] point_range,
  output logic [7:0]  point_reflectivity,
  output logic [19:0] delay_ns,
  output logic        range_valid,
  output logic        block_done
);

  lrai_pkg::dp_cmd_t    cmd;
  lrai_pkg::dp_status_t st;

  assign cfg_ready = 1'b1;

  lrai_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  lrai_dpath u_dpath (
    .clk                (clk),
    .rst                (rst),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .block_azimuth      (block_azimuth),
    .raw_range          (raw_range),
    .raw_reflectivity   (raw_reflectivity),
    .packet_end         (packet_end),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .laser_index        (laser_index),
    .half_index         (half_index),
    .point_azimuth      (point_azimuth),
    .point_range        (point_range),
    .point_reflectivity (point_reflectivity),
    .delay_ns           (delay_ns),
    .range_valid        (range_valid),
    .block_done         (block_done),
    .cmd                (cmd),
    .st                 (st)
  );

endmodule
